// File: hw/rtl/dstpm_pkg.sv
// Shared types and constants for the dual sensor threshold and period monitor.
// Holds the transfer payload structs, register indexes and event codes.
// No dependencies.
package dstpm_pkg;

	localparam int SENSOR_COUNT_DEF = 2;
	localparam int DATA_W = 32;
	localparam int CFG_AW = 5;
	localparam logic [DATA_W-1:0] DEBOUNCE_RESET = 32'd100;
	localparam logic [DATA_W-1:0] LAST_REPORTED_RESET = '1;

	localparam int OP_CALC_BIT = 0;
	localparam int OP_MSG_BIT = 1;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_MODES    = 3'd1,
		REG_PERIOD0  = 3'd2,
		REG_PERIOD1  = 3'd3,
		REG_LOW0     = 3'd4,
		REG_HIGH0    = 3'd5,
		REG_LOW1     = 3'd6,
		REG_HIGH1    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_OUTSIDE = 2'd1,
		MODE_INSIDE  = 2'd2,
		MODE_RSVD    = 2'd3
	} mode_t;

	localparam logic EV_PERIOD = 1'b0;
	localparam logic EV_THRESH = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] sample0;
		logic signed [31:0] sample1;
	} in_item_t;

	typedef struct packed {
		logic               event_kind;
		logic               sensor_index;
		logic signed [31:0] event_value;
		logic               last_event;
	} out_item_t;

	typedef struct packed {
		logic [31:0]        period;
		logic signed [31:0] low;
		logic signed [31:0] high;
	} sens_cfg_t;

endpackage

// File: hw/rtl/dstpm_cfg.sv
// Configuration register file with the APB-style write and read port.
// Produces the per-sensor settings and the debounce arming strobes.
// Depends on dstpm_pkg.
module dstpm_cfg #(
	parameter int SENSOR_COUNT = dstpm_pkg::SENSOR_COUNT_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [dstpm_pkg::CFG_AW-1:0]               paddr,
	input  logic [31:0]                                pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready,
	output logic [31:0]                                debounce_ticks,
	output logic [3:0]                                 threshold_modes,
	output dstpm_pkg::sens_cfg_t [SENSOR_COUNT-1:0]    scfg,
	output logic [SENSOR_COUNT-1:0]                    arm
);
	import dstpm_pkg::*;

	logic       wr;
	logic [2:0] idx;
	logic [31:0] debounce_q;
	logic [3:0]  modes_q;
	sens_cfg_t [SENSOR_COUNT-1:0] scfg_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			modes_q <= '0;
		end else if (wr) begin
			case (reg_idx_t'(idx))
				REG_DEBOUNCE: debounce_q <= pwdata;
				REG_MODES:    modes_q <= pwdata[3:0];
				default:      ;
			endcase
		end
	end

	for (genvar s = 0; s < SENSOR_COUNT; s++) begin : g_sens
		logic hit_period;
		logic hit_low;
		logic hit_high;

		assign hit_period = (idx == 3'(REG_PERIOD0) + 3'(s));
		assign hit_low = (idx == 3'(REG_LOW0) + 3'(2 * s));
		assign hit_high = (idx == 3'(REG_HIGH0) + 3'(2 * s));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				scfg_q[s] <= '0;
			end else if (wr) begin
				if (hit_period) begin
					scfg_q[s].period <= pwdata;
				end
				if (hit_low) begin
					scfg_q[s].low <= pwdata;
				end
				if (hit_high) begin
					scfg_q[s].high <= pwdata;
				end
			end
		end

		assign arm[s] = wr && (reg_idx_t'(idx) == REG_MODES || hit_low || hit_high);
	end

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(idx))
			REG_DEBOUNCE: prdata = debounce_q;
			REG_MODES:    prdata = {28'd0, modes_q};
			default:      ;
		endcase
		for (int s = 0; s < SENSOR_COUNT; s++) begin
			if (idx == 3'(REG_PERIOD0) + 3'(s)) begin
				prdata = scfg_q[s].period;
			end
			if (idx == 3'(REG_LOW0) + 3'(2 * s)) begin
				prdata = scfg_q[s].low;
			end
			if (idx == 3'(REG_HIGH0) + 3'(2 * s)) begin
				prdata = scfg_q[s].high;
			end
		end
	end

	assign debounce_ticks = debounce_q;
	assign threshold_modes = modes_q;
	assign scfg = scfg_q;

endmodule

// File: hw/rtl/dstpm_eval.sv
// Sensor state and single-pass tick evaluation.
// Updates values and counters on a step and lists the events of that tick in order.
// Depends on dstpm_pkg.
module dstpm_eval #(
	parameter int SENSOR_COUNT = dstpm_pkg::SENSOR_COUNT_DEF,
	localparam int EVW = 2 * SENSOR_COUNT,
	localparam int CW = $clog2(EVW + 1)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    step,
	input  logic [SENSOR_COUNT-1:0]                 arm,
	input  dstpm_pkg::in_item_t                     item,
	input  logic [31:0]                             debounce_ticks,
	input  logic [3:0]                              threshold_modes,
	input  dstpm_pkg::sens_cfg_t [SENSOR_COUNT-1:0] scfg,
	output dstpm_pkg::out_item_t [EVW-1:0]          ev,
	output logic [CW-1:0]                           ev_cnt
);
	import dstpm_pkg::*;

	localparam int IW = (EVW > 1) ? $clog2(EVW) : 1;

	logic calc;
	logic msg;
	logic [EVW-1:0] cand_v;
	out_item_t      cand [EVW];

	assign calc = item.opcode[OP_CALC_BIT];
	assign msg = item.opcode[OP_MSG_BIT];

	for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_sens
		logic signed [31:0] samp;
		logic signed [31:0] cur_n;
		logic [31:0]        pc_c;
		logic [31:0]        db_c;
		logic               per_hit;
		logic               th_hit;
		logic               outside;
		logic               in_win;
		logic [1:0]         mode;
		logic signed [31:0] cur_q;
		logic [31:0]        last_q;
		logic [31:0]        pc_q;
		logic [31:0]        db_q;

		if (i == 0) begin : g_s0
			assign samp = item.sample0;
		end else begin : g_s1
			assign samp = item.sample1;
		end

		assign cur_n = calc ? samp : cur_q;
		assign pc_c = (calc && pc_q != '1) ? pc_q + 32'd1 : pc_q;
		assign db_c = (calc && db_q != debounce_ticks) ? db_q + 32'd1 : db_q;
		assign per_hit = msg && scfg[i].period != '0 && scfg[i].period <= pc_c &&
			last_q != cur_n;
		assign mode = threshold_modes[2*i +: 2];
		assign outside = ($signed(cur_n) < $signed(scfg[i].low)) ||
			($signed(cur_n) > $signed(scfg[i].high));
		assign in_win = ($signed(cur_n) > $signed(scfg[i].low)) &&
			($signed(cur_n) < $signed(scfg[i].high));
		assign th_hit = msg && db_c == debounce_ticks &&
			((mode_t'(mode) == MODE_OUTSIDE && outside) ||
			(mode_t'(mode) == MODE_INSIDE && in_win));

		assign cand_v[i] = per_hit;
		assign cand[i] = '{event_kind: EV_PERIOD, sensor_index: 1'(i),
			event_value: cur_n, last_event: 1'b0};
		assign cand_v[SENSOR_COUNT + i] = th_hit;
		assign cand[SENSOR_COUNT + i] = '{event_kind: EV_THRESH, sensor_index: 1'(i),
			event_value: cur_n, last_event: 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cur_q <= '0;
				last_q <= LAST_REPORTED_RESET;
				pc_q <= '0;
				db_q <= '0;
			end else if (arm[i]) begin
				db_q <= debounce_ticks;
			end else if (step) begin
				cur_q <= cur_n;
				if (per_hit) begin
					last_q <= cur_n;
					pc_q <= '0;
				end else begin
					pc_q <= pc_c;
				end
				db_q <= th_hit ? '0 : db_c;
			end
		end
	end

	always_comb begin
		logic [CW-1:0] n;
		n = '0;
		ev = '0;
		for (int j = 0; j < EVW; j++) begin
			if (cand_v[j]) begin
				ev[n[IW-1:0]] = cand[j];
				n = n + CW'(1);
			end
		end
		for (int j = 0; j < EVW; j++) begin
			ev[j].last_event = (CW'(j + 1) == n);
		end
		ev_cnt = n;
	end

endmodule

// File: hw/rtl/dstpm_evbuf.sv
// Result buffer holding the events of one tick and handing them out one per transfer.
// A new tick's list loads when the buffer empties or its last entry leaves.
// Depends on dstpm_pkg.
module dstpm_evbuf #(
	parameter int SENSOR_COUNT = dstpm_pkg::SENSOR_COUNT_DEF,
	localparam int EVW = 2 * SENSOR_COUNT,
	localparam int CW = $clog2(EVW + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  dstpm_pkg::out_item_t [EVW-1:0] ev,
	input  logic [CW-1:0]                  ev_cnt,
	output logic                           can_load,
	output logic                           out_valid,
	input  logic                           out_stall,
	output dstpm_pkg::out_item_t           out_data
);
	import dstpm_pkg::*;

	out_item_t     slots_q [EVW];
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign can_load = (cnt_q == '0) || (cnt_q == CW'(1) && pop);
	assign out_data = slots_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ev_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < EVW; j++) begin
				slots_q[j] <= ev[j];
			end
		end else if (pop) begin
			for (int j = 0; j < EVW - 1; j++) begin
				slots_q[j] <= slots_q[j+1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(EVW))
		else $error("event buffer count above capacity");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'(1) |-> slots_q[0].last_event)
		else $error("final buffered event lacks last flag");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > CW'(1) |-> !slots_q[0].last_event)
		else $error("last flag set before final event");

endmodule

// File: hw/rtl/dual_sensor_threshold_period_monitor.sv
// Top level of the dual sensor threshold and period monitor.
// Instantiates dstpm_cfg, dstpm_eval and dstpm_evbuf; depends on dstpm_pkg.
//
// Usage: each input transfer carries one tick (opcode bit 0 calculation, bit 1
// message) and the two new samples. A tick raises zero to four events, which leave
// on the output channel one per transfer, in order: period events for sensor 0 and
// 1, then threshold events for sensor 0 and 1. The final event of a tick has
// last_event set; a tick with no event produces no output transfer.
// The accepted tick sits in an input register; it is evaluated in one pass and its
// whole event list loads into the result buffer, which also updates the state.
// A new list loads once the buffer is empty or its last event leaves, and the
// next tick is taken into the input register while earlier events still drain.
// When the receiver stalls, the buffer holds its head event and the input register
// fills, after which in_stall rises. Reset clears the valid flags, counters,
// sensor values and settings, sets the last reported values to all ones and
// debounce_ticks to 100. Configuration goes through the APB-style port with
// pready always high. The user must keep it written only while idle; the
// block itself does not enforce this.
module dual_sensor_threshold_period_monitor #(
	parameter int SENSOR_COUNT = dstpm_pkg::SENSOR_COUNT_DEF,
	localparam int EVW = 2 * SENSOR_COUNT,
	localparam int CW = $clog2(EVW + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  dstpm_pkg::in_item_t          in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output dstpm_pkg::out_item_t         out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dstpm_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import dstpm_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      load;
	logic      can_load;
	logic [31:0] debounce_ticks;
	logic [3:0]  threshold_modes;
	sens_cfg_t [SENSOR_COUNT-1:0] scfg;
	logic [SENSOR_COUNT-1:0]      arm;
	out_item_t [EVW-1:0]          ev;
	logic [CW-1:0]                ev_cnt;

	assign load = valid_s1 && can_load;
	assign in_stall = valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	dstpm_cfg #(.SENSOR_COUNT(SENSOR_COUNT)) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.debounce_ticks  (debounce_ticks),
		.threshold_modes (threshold_modes),
		.scfg            (scfg),
		.arm             (arm)
	);

	dstpm_eval #(.SENSOR_COUNT(SENSOR_COUNT)) u_eval (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (load),
		.arm             (arm),
		.item            (item_s1),
		.debounce_ticks  (debounce_ticks),
		.threshold_modes (threshold_modes),
		.scfg            (scfg),
		.ev              (ev),
		.ev_cnt          (ev_cnt)
	);

	dstpm_evbuf #(.SENSOR_COUNT(SENSOR_COUNT)) u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ev        (ev),
		.ev_cnt    (ev_cnt),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: tb/dstpm_check_pkg.sv
`timescale 1ns / 1ps
// Event predictor and checker for the dual sensor threshold and period monitor testbench.
// Depends on dstpm_pkg for the payload structs, register indexes and mode codes.
package dstpm_check_pkg;

	import dstpm_pkg::*;

	class sensor_event_model;
		bit [31:0] debounce_ticks;
		bit [3:0] modes;
		bit [31:0] period_ticks [SENSOR_COUNT_DEF];
		bit signed [31:0] win_low [SENSOR_COUNT_DEF];
		bit signed [31:0] win_high [SENSOR_COUNT_DEF];
		bit [31:0] value [SENSOR_COUNT_DEF];
		bit [31:0] reported [SENSOR_COUNT_DEF];
		bit [31:0] period_cnt [SENSOR_COUNT_DEF];
		bit [31:0] debounce_cnt [SENSOR_COUNT_DEF];
		out_item_t expected_events [$];
		int unsigned mismatches;

		function new();
			debounce_ticks = DEBOUNCE_RESET;
			modes = '0;
			for (int i = 0; i < SENSOR_COUNT_DEF; i++) begin
				period_ticks[i] = '0;
				win_low[i] = '0;
				win_high[i] = '0;
				value[i] = '0;
				reported[i] = LAST_REPORTED_RESET;
				period_cnt[i] = '0;
				debounce_cnt[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, bit [31:0] v);
			case (idx)
				REG_DEBOUNCE: debounce_ticks = v;
				REG_MODES: begin
					modes = v[3:0];
					debounce_cnt[0] = debounce_ticks;
					debounce_cnt[1] = debounce_ticks;
				end
				REG_PERIOD0: period_ticks[0] = v;
				REG_PERIOD1: period_ticks[1] = v;
				REG_LOW0: begin
					win_low[0] = v;
					debounce_cnt[0] = debounce_ticks;
				end
				REG_HIGH0: begin
					win_high[0] = v;
					debounce_cnt[0] = debounce_ticks;
				end
				REG_LOW1: begin
					win_low[1] = v;
					debounce_cnt[1] = debounce_ticks;
				end
				REG_HIGH1: begin
					win_high[1] = v;
					debounce_cnt[1] = debounce_ticks;
				end
				default: ;
			endcase
		endfunction

		function void note_tick(in_item_t t);
			out_item_t ev;
			out_item_t tick_events [$];
			mode_t mode;
			bit signed [31:0] v;
			bit hit;
			if (t.opcode[OP_CALC_BIT]) begin
				value[0] = t.sample0;
				value[1] = t.sample1;
				for (int i = 0; i < SENSOR_COUNT_DEF; i++) begin
					if (period_cnt[i] != '1)
						period_cnt[i]++;
					if (debounce_cnt[i] != debounce_ticks)
						debounce_cnt[i]++;
				end
			end
			if (t.opcode[OP_MSG_BIT]) begin
				for (int i = 0; i < SENSOR_COUNT_DEF; i++) begin
					if (period_ticks[i] != 0 && period_cnt[i] >= period_ticks[i] &&
							reported[i] != value[i]) begin
						ev.event_kind = EV_PERIOD;
						ev.sensor_index = (i == 1);
						ev.event_value = value[i];
						ev.last_event = 1'b0;
						tick_events.push_back(ev);
						period_cnt[i] = '0;
						reported[i] = value[i];
					end
				end
				for (int i = 0; i < SENSOR_COUNT_DEF; i++) begin
					mode = mode_t'(modes[2*i +: 2]);
					v = value[i];
					hit = (mode == MODE_OUTSIDE && (v < win_low[i] || v > win_high[i])) ||
						(mode == MODE_INSIDE && v > win_low[i] && v < win_high[i]);
					if (hit && debounce_cnt[i] == debounce_ticks) begin
						ev.event_kind = EV_THRESH;
						ev.sensor_index = (i == 1);
						ev.event_value = value[i];
						ev.last_event = 1'b0;
						tick_events.push_back(ev);
						debounce_cnt[i] = '0;
					end
				end
			end
			if (tick_events.size() > 0) begin
				ev = tick_events.pop_back();
				ev.last_event = 1'b1;
				tick_events.push_back(ev);
			end
			foreach (tick_events[k])
				expected_events.push_back(tick_events[k]);
		endfunction

		function void check_event(out_item_t got);
			out_item_t want;
			if (expected_events.size() == 0) begin
				$error("event transfer with none expected: kind %0d sensor %0d value %0d",
					got.event_kind, got.sensor_index, got.event_value);
				mismatches++;
				return;
			end
			want = expected_events.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind expected %0d got %0d", want.event_kind, got.event_kind);
				mismatches++;
			end
			if (got.sensor_index !== want.sensor_index) begin
				$error("sensor_index expected %0d got %0d", want.sensor_index, got.sensor_index);
				mismatches++;
			end
			if (got.event_value !== want.event_value) begin
				$error("event_value expected %0d got %0d", want.event_value, got.event_value);
				mismatches++;
			end
			if (got.last_event !== want.last_event) begin
				$error("last_event expected %0d got %0d", want.last_event, got.last_event);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction
	endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top level testbench for the dual sensor threshold and period monitor.
// Depends on dstpm_pkg, dstpm_check_pkg and the monitor RTL.
module tb;

	import dstpm_pkg::*;
	import dstpm_check_pkg::*;

	localparam logic [1:0] OP_NONE = 2'b00;
	localparam logic [1:0] OP_CALC = 2'(1 << OP_CALC_BIT);
	localparam logic [1:0] OP_MSG = 2'(1 << OP_MSG_BIT);
	localparam logic [1:0] OP_BOTH = OP_CALC | OP_MSG;
	localparam int unsigned LONG_HOLD = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sensor_event_model sb = new();
	bit tx_no_idle;
	bit rx_no_idle;
	bit hold_request;
	bit [31:0] last_s0;
	bit [31:0] last_s1;

	dual_sensor_threshold_period_monitor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic in_item_t tick(logic [1:0] op, bit [31:0] s0, bit [31:0] s1);
		in_item_t t;
		t.opcode = op;
		t.sample0 = s0;
		t.sample1 = s1;
		return t;
	endfunction

	function automatic bit [31:0] pick_sample(bit [31:0] prev);
		case ($urandom_range(0, 7))
			0: return prev;
			1: return $urandom();
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'(int'($urandom_range(0, 50)) - 25);
		endcase
	endfunction

	function automatic in_item_t make_tick();
		in_item_t t;
		case ($urandom_range(0, 7))
			0: t.opcode = OP_NONE;
			1: t.opcode = OP_CALC;
			2: t.opcode = OP_MSG;
			default: t.opcode = OP_BOTH;
		endcase
		last_s0 = pick_sample(last_s0);
		last_s1 = pick_sample(last_s1);
		t.sample0 = last_s0;
		t.sample1 = last_s1;
		return t;
	endfunction

	task automatic send_tick(in_item_t it);
		int unsigned gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_tick(it);
	endtask

	task automatic drain(int unsigned settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, bit [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		penable <= 1'b0;
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_window(reg_idx_t lo_idx, reg_idx_t hi_idx);
		bit [31:0] lo;
		bit [31:0] hi;
		if ($urandom_range(0, 7) == 0) begin
			lo = $urandom();
			hi = $urandom();
		end else begin
			lo = 32'(int'($urandom_range(0, 30)) - 20);
			hi = lo + $urandom_range(0, 30);
		end
		apb_write(lo_idx, lo);
		apb_write(hi_idx, hi);
	endtask

	task automatic random_config(bit busy);
		apb_write(REG_DEBOUNCE, $urandom_range(0, 3));
		apb_write(REG_PERIOD0, busy ? 32'd1 :
			($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4));
		apb_write(REG_PERIOD1, busy ? 32'd1 :
			($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4));
		random_window(REG_LOW0, REG_HIGH0);
		random_window(REG_LOW1, REG_HIGH1);
		apb_write(REG_MODES, $urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0)
			apb_write(REG_DEBOUNCE, $urandom_range(0, 4));
		apb_release();
	endtask

	initial begin : event_sink
		int unsigned gap;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = rx_no_idle ? 0 : $urandom_range(0, 17);
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid || out_stall);
			sb.check_event(out_data);
		end
	end

	initial begin : stimulus
		in_item_t directed [$];
		int unsigned style;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		hold_request = 1'b0;
		last_s0 = '0;
		last_s1 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: periods and thresholds are off, so nothing is raised.
		directed = {tick(OP_NONE, 0, 0), tick(OP_CALC, '1, '1), tick(OP_MSG, 0, 0),
			tick(OP_BOTH, 5, 6)};
		foreach (directed[k])
			send_tick(directed[k]);
		drain(8);

		apb_write(REG_DEBOUNCE, 0);
		apb_write(REG_PERIOD0, 1);
		apb_write(REG_PERIOD1, 1);
		apb_write(REG_LOW0, -10);
		apb_write(REG_HIGH0, 10);
		apb_write(REG_LOW1, 32'h8000_0000);
		apb_write(REG_HIGH1, 32'h7FFF_FFFF);
		apb_write(REG_MODES, 32'({MODE_INSIDE, MODE_OUTSIDE}));
		apb_release();
		// A sensor 1 value of all ones matches the reset of the last reported value.
		directed = {tick(OP_BOTH, 32'h7FFF_FFFF, '1), tick(OP_BOTH, '1, 32'h8000_0000),
			tick(OP_BOTH, -11, 0), tick(OP_BOTH, 10, 0), tick(OP_BOTH, 11, -5),
			tick(OP_CALC, -10, 3), tick(OP_MSG, 0, 0)};
		foreach (directed[k])
			send_tick(directed[k]);
		drain(8);

		apb_write(REG_DEBOUNCE, '1);
		apb_write(REG_PERIOD0, '1);
		apb_write(REG_PERIOD1, 0);
		apb_write(REG_LOW0, 32'h7FFF_FFFF);
		apb_write(REG_HIGH0, 32'h8000_0000);
		apb_write(REG_LOW1, 0);
		apb_write(REG_HIGH1, 0);
		apb_write(REG_MODES, 32'({MODE_OUTSIDE, MODE_RSVD}));
		apb_release();
		directed = {tick(OP_BOTH, 1, 2), tick(OP_BOTH, 3, 4), tick(OP_CALC, 0, 0),
			tick(OP_MSG, 0, 0)};
		foreach (directed[k])
			send_tick(directed[k]);
		drain(8);

		// Lowering the debounce setting below the armed count leaves the count above it.
		apb_write(REG_DEBOUNCE, 5);
		apb_write(REG_PERIOD0, 2);
		apb_write(REG_PERIOD1, 3);
		apb_write(REG_LOW0, -1);
		apb_write(REG_HIGH0, 1);
		apb_write(REG_LOW1, -1);
		apb_write(REG_HIGH1, 1);
		apb_write(REG_MODES, 32'({MODE_OUTSIDE, MODE_OUTSIDE}));
		apb_write(REG_DEBOUNCE, 2);
		apb_release();
		directed = {tick(OP_BOTH, 100, -100), tick(OP_BOTH, 101, -101),
			tick(OP_BOTH, 102, -102), tick(OP_BOTH, 103, -103), tick(OP_MSG, 0, 0)};
		foreach (directed[k])
			send_tick(directed[k]);
		drain(8);

		for (int phase = 0; phase < 10; phase++) begin
			random_config(phase == 2);
			style = $urandom_range(0, 3);
			tx_no_idle = style[0] || phase == 2;
			rx_no_idle = style[1];
			if (phase == 2)
				hold_request = 1'b1;
			for (int n = 0; n < 25; n++) begin
				if (phase == 5 && n == 12)
					drain(0);
				send_tick(make_tick());
			end
			drain(8);
		end

		drain(10);
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
